// ===== sv/assert_macros.svh =====
// assertion helpers used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BQC_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define BQC_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/bqc_pkg.sv =====
`default_nettype none

package bqc_pkg;

   localparam int BANDS          = 8;
   localparam int SAMPLE_WIDTH   = 24;
   localparam int COEF_FRAC_BITS = 26;

   localparam int STAGES      = BANDS + 2;
   localparam int LAST_STAGE  = STAGES - 1;
   localparam int COEF_WORDS  = STAGES * 5 + 2;
   localparam int MIX_HIGH    = STAGES * 5;
   localparam int MIX_LOW     = STAGES * 5 + 1;
   localparam int DELAY_WORDS = STAGES * 4;
   localparam int DELAY_WIDTH = 48;
   localparam int GUARD       = 16;
   localparam int COEF_WIDTH  = 32;
   localparam int PROD_SHIFT  = COEF_FRAC_BITS - GUARD;

   localparam int STAGE_W = $clog2(STAGES);
   localparam int CADDR_W = $clog2(COEF_WORDS);
   localparam int DADDR_W = STAGE_W + 2;
   localparam int OPND_W  = SAMPLE_WIDTH + 1;
   localparam int PROD_W  = COEF_WIDTH + OPND_W;
   localparam int ACC_W   = DELAY_WIDTH + 2;

   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'sd1 <<< COEF_FRAC_BITS);

   localparam logic signed [ACC_W:0] SMP_MAX = (ACC_W+1)'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1);
   localparam logic signed [ACC_W:0] SMP_MIN = -SMP_MAX - (ACC_W+1)'(1);
   localparam logic signed [ACC_W-1:0] DLY_MAX = ACC_W'((64'sd1 <<< (DELAY_WIDTH-1)) - 1);
   localparam logic signed [ACC_W-1:0] DLY_MIN = -DLY_MAX - ACC_W'(1);

   typedef enum logic [1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_WRITE  = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef struct packed {
      action_type                     action;
      logic signed [SAMPLE_WIDTH-1:0] left_in;
      logic signed [SAMPLE_WIDTH-1:0] right_in;
      logic [5:0]                     coef_addr;
      logic signed [COEF_WIDTH-1:0]   coef_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] left_out;
      logic signed [SAMPLE_WIDTH-1:0] right_out;
   } rsp_type;

   typedef enum logic [1:0] {SRC_X, SRC_Y, SRC_DIFF} src_type;
   typedef enum logic [2:0] {ACC_HOLD, ACC_LOADZ, ACC_ADD, ACC_SUB, ACC_SET} acc_op_type;
   typedef enum logic [1:0] {X_HOLD, X_LOAD, X_Y, X_MIX} x_op_type;

   typedef struct packed {
      logic       mul_en;
      src_type    src;
      acc_op_type acc_op;
      logic       y_load;
      x_op_type   x_op;
   } dp_ctrl_type;

   typedef struct packed {
      logic               rd_en;
      logic [CADDR_W-1:0] addr;
      logic               dflt_one;
   } coef_rd_type;

   typedef struct packed {
      logic               rd_en;
      logic [DADDR_W-1:0] rd_addr;
      logic               wr_en;
      logic [DADDR_W-1:0] wr_addr;
   } dly_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_B0_RD, ST_B0_MUL, ST_Y_CALC, ST_B1_RD, ST_B1_MUL, ST_B1_ACC,
      ST_A1_MUL, ST_A1_ACC, ST_B2_RD, ST_B2_MUL, ST_B2_SET, ST_A2_MUL, ST_A2_ACC,
      ST_Z2_WR, ST_MIX_RD, ST_MIX_MUL, ST_MIX_OUT, ST_CH_END, ST_DONE
   } state_type;

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
      input logic signed [ACC_W:0] v);
      logic signed [SAMPLE_WIDTH-1:0] r;
      if (v > SMP_MAX) r = SMP_MAX[SAMPLE_WIDTH-1:0];
      else if (v < SMP_MIN) r = SMP_MIN[SAMPLE_WIDTH-1:0];
      else r = v[SAMPLE_WIDTH-1:0];
      return r;
   endfunction

   function automatic logic signed [DELAY_WIDTH-1:0] sat_delay(
      input logic signed [ACC_W-1:0] v);
      logic signed [DELAY_WIDTH-1:0] r;
      if (v > DLY_MAX) r = DLY_MAX[DELAY_WIDTH-1:0];
      else if (v < DLY_MIN) r = DLY_MIN[DELAY_WIDTH-1:0];
      else r = v[DELAY_WIDTH-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/bqc_coef_store.sv =====
`default_nettype none

module bqc_coef_store
   import bqc_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [CADDR_W-1:0]           wr_addr,
   input  wire logic signed [COEF_WIDTH-1:0] wr_data,
   input  wire coef_rd_type                  rd,
   output logic signed [COEF_WIDTH-1:0]      rd_data
);

   logic signed [COEF_WIDTH-1:0] mem [COEF_WORDS];
   logic [COEF_WORDS-1:0]        valid_ff;
   logic signed [COEF_WIDTH-1:0] rd_data_ff;

   // unwritten words read as one when dflt_one is set, else as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd.rd_en) begin
         if (valid_ff[rd.addr]) rd_data_ff <= mem[rd.addr];
         else if (rd.dflt_one) rd_data_ff <= COEF_ONE;
         else rd_data_ff <= '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/bqc_delay_store.sv =====
`default_nettype none

module bqc_delay_store
   import bqc_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clear,
   input  wire dly_ctl_type                   ctl,
   input  wire logic signed [DELAY_WIDTH-1:0] wr_data,
   output logic signed [DELAY_WIDTH-1:0]      rd_data
);

   logic signed [DELAY_WIDTH-1:0] mem [DELAY_WORDS];
   logic [DELAY_WORDS-1:0]        valid_ff;
   logic signed [DELAY_WIDTH-1:0] rd_data_ff;

   // cleared words read as zero
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= valid_ff[ctl.rd_addr] ? mem[ctl.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/bqc_datapath.sv =====
`default_nettype none

module bqc_datapath
   import bqc_pkg::*;
(
   input  wire logic                           clock,
   input  wire dp_ctrl_type                    ctrl,
   input  wire logic signed [COEF_WIDTH-1:0]   coef,
   input  wire logic signed [DELAY_WIDTH-1:0]  zdata,
   input  wire logic signed [SAMPLE_WIDTH-1:0] load_val,
   output logic signed [SAMPLE_WIDTH-1:0]      x_out,
   output logic signed [DELAY_WIDTH-1:0]       z_wr
);

   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [OPND_W-1:0]       opnd;
   logic signed [PROD_W-1:0]       psh;
   logic signed [ACC_W:0]          sum_add, sum_sub, y_sum, mix_sum;
   logic signed [PROD_W-1:0]       mix_d;

   always_comb begin
      unique case (ctrl.src)
         SRC_X:    opnd = OPND_W'(x_ff);
         SRC_Y:    opnd = OPND_W'(y_ff);
         SRC_DIFF: opnd = OPND_W'(y_ff) - OPND_W'(x_ff);
         default:  opnd = '0;
      endcase
   end

   // the one shared multiplier
   assign prod_in = ctrl.mul_en ? PROD_W'(coef) * PROD_W'(opnd) : prod_ff;

   // product at delay scale
   assign psh     = prod_ff >>> PROD_SHIFT;
   assign sum_add = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(psh);
   assign sum_sub = (ACC_W+1)'(acc_ff) - (ACC_W+1)'(psh);
   assign y_sum   = (sum_add + (ACC_W+1)'(64'sd1 <<< (GUARD-1))) >>> GUARD;
   assign mix_d   = (prod_ff + PROD_W'(64'sd1 <<< (COEF_FRAC_BITS-1))) >>> COEF_FRAC_BITS;
   assign mix_sum = (ACC_W+1)'(x_ff) + (ACC_W+1)'(mix_d);

   always_comb begin
      unique case (ctrl.acc_op)
         ACC_HOLD:  acc_in = acc_ff;
         ACC_LOADZ: acc_in = ACC_W'(zdata);
         ACC_ADD:   acc_in = sum_add[ACC_W-1:0];
         ACC_SUB:   acc_in = sum_sub[ACC_W-1:0];
         ACC_SET:   acc_in = ACC_W'(psh);
         default:   acc_in = acc_ff;
      endcase
   end

   assign y_in = ctrl.y_load ? sat_sample(y_sum) : y_ff;

   always_comb begin
      unique case (ctrl.x_op)
         X_HOLD:  x_in = x_ff;
         X_LOAD:  x_in = load_val;
         X_Y:     x_in = y_ff;
         X_MIX:   x_in = sat_sample(mix_sum);
         default: x_in = x_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      y_ff    <= y_in;
      x_ff    <= x_in;
   end

   assign x_out = x_ff;
   assign z_wr  = sat_delay(acc_ff);

endmodule

`default_nettype wire

// ===== sv/stereo_biquad_eq_cascade_top.sv =====
// a sample runs the left channel through every stage, then the right, then gives a result
// one sample at a time on the single shared multiplier; no request is taken until idle
// done holds while an earlier result is still unread
// write, clear and no-op transactions are accepted in idle and give no result
// reset: synchronous, active high; coefficients read as identity, delay state as zero
`default_nettype none
`include "assert_macros.svh"

module stereo_biquad_eq_cascade_top
   import bqc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   state_type state_ff, state_in;
   logic [STAGE_W-1:0]             stage_ff;
   logic                           ch_ff;
   logic signed [SAMPLE_WIDTH-1:0] right_ff, left_ff;
   logic                           rsp_valid_ff;
   rsp_type                        rsp_ff;

   dp_ctrl_type                    ctrl;
   coef_rd_type                    crd;
   dly_ctl_type                    dctl;
   logic signed [COEF_WIDTH-1:0]   coef;
   logic signed [DELAY_WIDTH-1:0]  zdata, z_wr;
   logic signed [SAMPLE_WIDTH-1:0] x_cur, load_val;

   logic req_acc, smp_acc, cwr_en, dclr, edge_stage, rsp_free;
   logic [CADDR_W-1:0] stage_base;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign smp_acc   = req_acc && (req_payload.action == ACT_SAMPLE);
   // out-of-range word addresses are dropped
   assign cwr_en    = req_acc && (req_payload.action == ACT_WRITE)
                      && (7'(req_payload.coef_addr) < 7'(COEF_WORDS));
   assign dclr      = req_acc && (req_payload.action == ACT_CLEAR);

   // high-pass and low-pass stages are followed by a wet/dry blend
   assign edge_stage = (stage_ff == '0) || (stage_ff == STAGE_W'(LAST_STAGE));
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign stage_base = CADDR_W'({stage_ff, 2'b00}) + CADDR_W'(stage_ff);
   assign load_val   = (state_ff == ST_IDLE) ? req_payload.left_in : right_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (smp_acc) state_in = ST_B0_RD;
         ST_B0_RD:   state_in = ST_B0_MUL;
         ST_B0_MUL:  state_in = ST_Y_CALC;
         ST_Y_CALC:  state_in = ST_B1_RD;
         ST_B1_RD:   state_in = ST_B1_MUL;
         ST_B1_MUL:  state_in = ST_B1_ACC;
         ST_B1_ACC:  state_in = ST_A1_MUL;
         ST_A1_MUL:  state_in = ST_A1_ACC;
         ST_A1_ACC:  state_in = ST_B2_RD;
         ST_B2_RD:   state_in = ST_B2_MUL;
         ST_B2_MUL:  state_in = ST_B2_SET;
         ST_B2_SET:  state_in = ST_A2_MUL;
         ST_A2_MUL:  state_in = ST_A2_ACC;
         ST_A2_ACC:  state_in = ST_Z2_WR;
         ST_Z2_WR:   state_in = edge_stage ? ST_MIX_RD : ST_B0_RD;
         ST_MIX_RD:  state_in = ST_MIX_MUL;
         ST_MIX_MUL: state_in = ST_MIX_OUT;
         ST_MIX_OUT: state_in = (stage_ff == '0) ? ST_B0_RD : ST_CH_END;
         ST_CH_END:  state_in = ch_ff ? ST_DONE : ST_B0_RD;
         ST_DONE:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: memory reads and writes, datapath steps
   always_comb begin
      ctrl          = '{mul_en: 1'b0, src: SRC_X, acc_op: ACC_HOLD, y_load: 1'b0, x_op: X_HOLD};
      crd.rd_en     = 1'b0;
      crd.addr      = stage_base;
      crd.dflt_one  = 1'b0;
      dctl.rd_en    = 1'b0;
      dctl.rd_addr  = {stage_ff, ch_ff, 1'b0};
      dctl.wr_en    = 1'b0;
      dctl.wr_addr  = {stage_ff, ch_ff, 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (smp_acc) ctrl.x_op = X_LOAD;
         end
         ST_B0_RD: begin
            // b0 and z1
            crd.rd_en    = 1'b1;
            crd.dflt_one = 1'b1;
            dctl.rd_en   = 1'b1;
         end
         ST_B0_MUL: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_LOADZ;
         end
         ST_Y_CALC: ctrl.y_load = 1'b1;
         ST_B1_RD: begin
            // b1 and z2
            crd.rd_en    = 1'b1;
            crd.addr     = stage_base + CADDR_W'(1);
            dctl.rd_en   = 1'b1;
            dctl.rd_addr = {stage_ff, ch_ff, 1'b1};
         end
         ST_B1_MUL: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_LOADZ;
         end
         ST_B1_ACC: begin
            ctrl.acc_op = ACC_ADD;
            crd.rd_en   = 1'b1;
            crd.addr    = stage_base + CADDR_W'(3);
         end
         ST_A1_MUL: begin
            ctrl.mul_en = 1'b1;
            ctrl.src    = SRC_Y;
         end
         ST_A1_ACC: ctrl.acc_op = ACC_SUB;
         ST_B2_RD: begin
            // new z1 goes back while b2 is fetched
            dctl.wr_en = 1'b1;
            crd.rd_en  = 1'b1;
            crd.addr   = stage_base + CADDR_W'(2);
         end
         ST_B2_MUL: ctrl.mul_en = 1'b1;
         ST_B2_SET: begin
            ctrl.acc_op = ACC_SET;
            crd.rd_en   = 1'b1;
            crd.addr    = stage_base + CADDR_W'(4);
         end
         ST_A2_MUL: begin
            ctrl.mul_en = 1'b1;
            ctrl.src    = SRC_Y;
         end
         ST_A2_ACC: ctrl.acc_op = ACC_SUB;
         ST_Z2_WR: begin
            dctl.wr_en   = 1'b1;
            dctl.wr_addr = {stage_ff, ch_ff, 1'b1};
            if (!edge_stage) ctrl.x_op = X_Y;
         end
         ST_MIX_RD: begin
            crd.rd_en = 1'b1;
            crd.addr  = (stage_ff == '0) ? CADDR_W'(MIX_HIGH) : CADDR_W'(MIX_LOW);
         end
         ST_MIX_MUL: begin
            ctrl.mul_en = 1'b1;
            ctrl.src    = SRC_DIFF;
         end
         ST_MIX_OUT: ctrl.x_op = X_MIX;
         ST_CH_END: begin
            if (!ch_ff) ctrl.x_op = X_LOAD;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         stage_ff     <= '0;
         ch_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (smp_acc) begin
            stage_ff <= '0;
            ch_ff    <= 1'b0;
         end else if (state_ff == ST_Z2_WR && !edge_stage) begin
            stage_ff <= stage_ff + STAGE_W'(1);
         end else if (state_ff == ST_MIX_OUT && stage_ff == '0) begin
            stage_ff <= STAGE_W'(1);
         end else if (state_ff == ST_CH_END && !ch_ff) begin
            stage_ff <= '0;
            ch_ff    <= 1'b1;
         end
      end
   end

   // sample and result holding registers
   always_ff @(posedge clock) begin
      if (smp_acc) right_ff <= req_payload.right_in;
      if (state_ff == ST_CH_END && !ch_ff) left_ff <= x_cur;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_ff.left_out  <= left_ff;
         rsp_ff.right_out <= x_cur;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   bqc_coef_store u_coef (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cwr_en),
      .wr_addr (CADDR_W'(req_payload.coef_addr)),
      .wr_data (req_payload.coef_value),
      .rd      (crd),
      .rd_data (coef)
   );

   bqc_delay_store u_delay (
      .clock   (clock),
      .reset   (reset),
      .clear   (dclr),
      .ctl     (dctl),
      .wr_data (z_wr),
      .rd_data (zdata)
   );

   bqc_datapath u_dp (
      .clock    (clock),
      .ctrl     (ctrl),
      .coef     (coef),
      .zdata    (zdata),
      .load_val (load_val),
      .x_out    (x_cur),
      .z_wr     (z_wr)
   );

   // a sample transaction starts the left channel at the high-pass stage
   `BQC_ASSERT_NXT(a_start, smp_acc, state_ff == ST_B0_RD && stage_ff == '0 && !ch_ff)
   // stage counter never runs past the low-pass stage
   `BQC_ASSERT_IMP(a_stage_rng, state_ff != ST_IDLE, stage_ff <= STAGE_W'(LAST_STAGE))
   // leaving done always presents a result
   `BQC_ASSERT_NXT(a_done_rsp, state_ff == ST_DONE && rsp_free,
                   rsp_valid_ff && state_ff == ST_IDLE)

endmodule

`default_nettype wire
